// ===== src/bnpt_pkg.sv =====
// Shared types and constants for the bus node presence table.
// No dependencies; imported by the core.
package bnpt_pkg;

  // Default table size
  localparam int TABLE_DEPTH_DEF = 8;

  // Field widths
  localparam int REQ_W  = 2;
  localparam int TIME_W = 32;
  localparam int ID_W   = 11;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 4;
  localparam int SEL_W  = 3;
  localparam int EV_W   = 4;
  localparam int TYPE_W = 6;
  localparam int CNT32  = 32;
  localparam int USED_W = 4;
  localparam int CFG_W  = 32;
  localparam int CFG_IDX_W = 1;

  // Node type sits in the upper id bits
  localparam int TYPE_SHIFT = 5;

  // Configuration register reset values
  localparam logic [TIME_W-1:0] TIMEOUT_DEF   = 32'd5000;
  localparam logic [BYTE_W-1:0] HEARTBEAT_DEF = 8'd0;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT = 1'd1;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_FRAME = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SWEEP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

  // Event codes
  localparam logic [EV_W-1:0] EV_COUNTED  = 4'd0;
  localparam logic [EV_W-1:0] EV_ADDED    = 4'd1;
  localparam logic [EV_W-1:0] EV_FULL     = 4'd2;
  localparam logic [EV_W-1:0] EV_NO_SEND  = 4'd3;
  localparam logic [EV_W-1:0] EV_DOWN     = 4'd4;
  localparam logic [EV_W-1:0] EV_UP       = 4'd5;
  localparam logic [EV_W-1:0] EV_SWEPT    = 4'd6;
  localparam logic [EV_W-1:0] EV_READ     = 4'd7;
  localparam logic [EV_W-1:0] EV_EMPTY    = 4'd8;

  // One table entry
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TYPE_W-1:0] ntype;
    logic              up;
    logic [CNT32-1:0]  cnt;
    logic [TIME_W-1:0] first;
    logic [TIME_W-1:0] last;
    logic [TIME_W-1:0] beat;
  } entry_t;

endpackage

// ===== src/bus_node_presence_table_core.sv =====
// Bus node presence table: node table memory, scan sequencer and result register.
// Depends on bnpt_pkg.
// Frame: accept, then a lookup (one slot read per cycle from the table memory, one id
// compare per cycle), then the update; a zero sender id or a full table gives a plain result.
// Sweep: a pass through the subtract-and-compare unit, then the done beat; the pass
// also holds while a flip result waits on out_stall. Read: table read, then the result.
// Reset (rst_n low, synchronous) clears control, fill level, frame total and the
// configuration; table contents are left as they are and no clearing pass is run.
module bus_node_presence_table_core #(
  parameter int TABLE_DEPTH = bnpt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [bnpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bnpt_pkg::CFG_W-1:0]      cfg_wdata,
  // input beats
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bnpt_pkg::REQ_W-1:0]      in_req_type,
  input  logic [bnpt_pkg::TIME_W-1:0]     in_now_ms,
  input  logic [bnpt_pkg::ID_W-1:0]       in_sender_id,
  input  logic [bnpt_pkg::BYTE_W-1:0]     in_first_byte,
  input  logic [bnpt_pkg::LEN_W-1:0]      in_frame_len,
  input  logic [bnpt_pkg::SEL_W-1:0]      in_entry_index,
  // result beats
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bnpt_pkg::EV_W-1:0]       out_event_res,
  output logic [bnpt_pkg::SEL_W-1:0]      out_slot,
  output logic [bnpt_pkg::ID_W-1:0]       out_node_id,
  output logic [bnpt_pkg::TYPE_W-1:0]     out_node_type,
  output logic                            out_is_up,
  output logic [bnpt_pkg::CNT32-1:0]      out_node_msgs,
  output logic [bnpt_pkg::CNT32-1:0]      out_total_frames,
  output logic [bnpt_pkg::TIME_W-1:0]     out_seen_first,
  output logic [bnpt_pkg::TIME_W-1:0]     out_seen_last,
  output logic [bnpt_pkg::TIME_W-1:0]     out_beat_last,
  output logic [bnpt_pkg::USED_W-1:0]     out_used_slots,
  output logic                            out_last_item
);
  import bnpt_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int EXT_W = (CNT_W > SEL_W) ? CNT_W + 1 : SEL_W + 1;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_RDOUT = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  // Control and configuration registers
  logic [2:0]        state_r,   state_nxt;
  logic [TIME_W-1:0] timeout_r;
  logic [BYTE_W-1:0] hbcode_r;
  logic [CNT_W-1:0]  fill_r,    fill_nxt;
  logic [CNT32-1:0]  total_r,   total_nxt;
  logic [CNT_W-1:0]  ai_r,      ai_nxt;
  logic              pend_r,    pend_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Captured item and working registers
  logic [REQ_W-1:0]  req_r,   req_nxt;
  logic [TIME_W-1:0] now_r,   now_nxt;
  logic [ID_W-1:0]   id_r,    id_nxt;
  logic [BYTE_W-1:0] fb_r,    fb_nxt;
  logic [LEN_W-1:0]  len_r,   len_nxt;
  logic [IDX_W-1:0]  ci_r,    ci_nxt;
  logic [IDX_W-1:0]  slot_r,  slot_nxt;
  logic [SEL_W-1:0]  sel_r,   sel_nxt;
  logic [EV_W-1:0]   ev_r,    ev_nxt;
  entry_t            ent_r,   ent_nxt;

  // Result register
  logic [EV_W-1:0]   out_ev_r;
  logic [SEL_W-1:0]  out_slot_r;
  entry_t            out_ent_r;
  logic [CNT32-1:0]  out_total_r;
  logic [USED_W-1:0] out_used_r;
  logic              out_last_r;

  // Table memory
  entry_t            tbl_mem [TABLE_DEPTH];
  entry_t            rd_q;
  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  entry_t            wr_data;

  // Emit request to the result register
  logic              emit;
  logic [EV_W-1:0]   em_ev;
  logic [SEL_W-1:0]  em_slot;
  entry_t            em_ent;
  logic              em_last;

  logic              out_free;
  logic              in_acc;
  logic              id_hit;
  logic [TIME_W-1:0] idle_ms;
  logic              idle_gt;
  logic              flip;
  logic              can_issue;
  logic              idx_ok;
  entry_t            upd_ent;
  entry_t            sw_ent;
  entry_t            new_ent;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Compare logic on the read entry: id match for lookups, idle time against timeout for sweeps
  assign id_hit  = (rd_q.id == id_r);
  assign idle_ms = now_r - rd_q.last;
  assign idle_gt = (idle_ms > timeout_r);
  assign flip    = (rd_q.up == idle_gt);

  assign can_issue = (ai_r < fill_r);
  assign idx_ok    = (EXT_W'(in_entry_index) < EXT_W'(fill_r)) &&
                     (EXT_W'(in_entry_index) < EXT_W'(TABLE_DEPTH));

  // Entry after a frame from its node
  always_comb begin
    upd_ent      = ent_r;
    upd_ent.last = now_r;
    upd_ent.cnt  = ent_r.cnt + 32'd1;
    upd_ent.up   = 1'b1;
    if ((len_r != '0) && (fb_r == hbcode_r)) begin
      upd_ent.beat = now_r;
    end
  end

  // Entry with its connected flag flipped by the sweep
  always_comb begin
    sw_ent    = rd_q;
    sw_ent.up = !rd_q.up;
  end

  // Fresh entry for a new sender
  always_comb begin
    new_ent       = '0;
    new_ent.id    = id_r;
    new_ent.ntype = id_r[TYPE_SHIFT +: TYPE_W];
    new_ent.first = now_r;
    new_ent.beat  = now_r;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    total_nxt = total_r;
    ai_nxt    = ai_r;
    pend_nxt  = pend_r;
    req_nxt   = req_r;
    now_nxt   = now_r;
    id_nxt    = id_r;
    fb_nxt    = fb_r;
    len_nxt   = len_r;
    ci_nxt    = ci_r;
    slot_nxt  = slot_r;
    sel_nxt   = sel_r;
    ev_nxt    = ev_r;
    ent_nxt   = ent_r;
    rd_en     = 1'b0;
    rd_addr   = ai_r[IDX_W-1:0];
    wr_en     = 1'b0;
    wr_addr   = slot_r;
    wr_data   = upd_ent;
    emit      = 1'b0;
    em_ev     = ev_r;
    em_slot   = sel_r;
    em_ent    = '0;
    em_last   = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_nxt  = in_req_type;
          now_nxt  = in_now_ms;
          id_nxt   = in_sender_id;
          fb_nxt   = in_first_byte;
          len_nxt  = in_frame_len;
          sel_nxt  = '0;
          ai_nxt   = '0;
          pend_nxt = 1'b0;
          unique case (in_req_type)
            REQ_FRAME: begin
              total_nxt = total_r + 32'd1;
              if (in_sender_id == '0) begin
                ev_nxt    = EV_NO_SEND;
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            REQ_SWEEP: begin
              state_nxt = S_SCAN;
            end
            REQ_READ: begin
              sel_nxt = in_entry_index;
              if (idx_ok) begin
                rd_en     = 1'b1;
                rd_addr   = IDX_W'(in_entry_index);
                state_nxt = S_RDOUT;
              end else begin
                ev_nxt    = EV_EMPTY;
                state_nxt = S_EMIT;
              end
            end
            default: begin
              // unused request code: drop
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (req_r == REQ_FRAME) begin
          if (pend_r && id_hit) begin
            // known sender
            ent_nxt   = rd_q;
            slot_nxt  = ci_r;
            ev_nxt    = EV_COUNTED;
            state_nxt = S_UPD;
          end else if (can_issue) begin
            rd_en    = 1'b1;
            ai_nxt   = ai_r + CNT_W'(1);
            ci_nxt   = ai_r[IDX_W-1:0];
            pend_nxt = 1'b1;
          end else if (pend_r) begin
            pend_nxt = 1'b0;
          end else if (fill_r < CNT_W'(TABLE_DEPTH)) begin
            // new sender, room left
            ent_nxt   = new_ent;
            slot_nxt  = fill_r[IDX_W-1:0];
            ev_nxt    = EV_ADDED;
            state_nxt = S_UPD;
          end else begin
            ev_nxt    = EV_FULL;
            state_nxt = S_EMIT;
          end
        end else begin
          // sweep: hold while a flip waits for the result register
          if (!(pend_r && flip && !out_free)) begin
            if (pend_r && flip) begin
              wr_en   = 1'b1;
              wr_addr = ci_r;
              wr_data = sw_ent;
              emit    = 1'b1;
              em_ev   = rd_q.up ? EV_DOWN : EV_UP;
              em_slot = SEL_W'(ci_r);
              em_ent  = sw_ent;
              em_last = 1'b0;
            end
            if (can_issue) begin
              rd_en    = 1'b1;
              ai_nxt   = ai_r + CNT_W'(1);
              ci_nxt   = ai_r[IDX_W-1:0];
              pend_nxt = 1'b1;
            end else if (pend_r) begin
              pend_nxt = 1'b0;
            end else begin
              ev_nxt    = EV_SWEPT;
              state_nxt = S_EMIT;
            end
          end
        end
      end

      S_UPD: begin
        if (out_free) begin
          wr_en   = 1'b1;
          wr_addr = slot_r;
          wr_data = upd_ent;
          if (ev_r == EV_ADDED) begin
            fill_nxt = fill_r + CNT_W'(1);
          end
          emit      = 1'b1;
          em_slot   = SEL_W'(slot_r);
          em_ent    = upd_ent;
          state_nxt = S_IDLE;
        end
      end

      S_RDOUT: begin
        // read data stays put until taken
        if (out_free) begin
          emit      = 1'b1;
          em_ev     = EV_READ;
          em_ent    = rd_q;
          state_nxt = S_IDLE;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      total_r     <= '0;
      ai_r        <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      timeout_r   <= TIMEOUT_DEF;
      hbcode_r    <= HEARTBEAT_DEF;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      total_r     <= total_nxt;
      ai_r        <= ai_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TIMEOUT:   timeout_r <= cfg_wdata;
          REG_HEARTBEAT: hbcode_r  <= cfg_wdata[BYTE_W-1:0];
          default:       timeout_r <= timeout_r;
        endcase
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    now_r  <= now_nxt;
    id_r   <= id_nxt;
    fb_r   <= fb_nxt;
    len_r  <= len_nxt;
    ci_r   <= ci_nxt;
    slot_r <= slot_nxt;
    sel_r  <= sel_nxt;
    ev_r   <= ev_nxt;
    ent_r  <= ent_nxt;
  end

  // Result payload: load on emit
  always_ff @(posedge clk) begin
    if (emit) begin
      out_ev_r    <= em_ev;
      out_slot_r  <= em_slot;
      out_ent_r   <= em_ent;
      out_total_r <= total_r;
      out_used_r  <= USED_W'(fill_nxt);
      out_last_r  <= em_last;
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= tbl_mem[rd_addr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = out_ev_r;
  assign out_slot         = out_slot_r;
  assign out_node_id      = out_ent_r.id;
  assign out_node_type    = out_ent_r.ntype;
  assign out_is_up        = out_ent_r.up;
  assign out_node_msgs    = out_ent_r.cnt;
  assign out_total_frames = out_total_r;
  assign out_seen_first   = out_ent_r.first;
  assign out_seen_last    = out_ent_r.last;
  assign out_beat_last    = out_ent_r.beat;
  assign out_used_slots   = out_used_r;
  assign out_last_item    = out_last_r;

`ifndef SYNTHESIS
  // Only sweep flips leave a beat that is not the last of its item
  a_mid_beat_is_flip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> (out_ev_r == EV_DOWN || out_ev_r == EV_UP))
    else $error("non-final result beat is not a sweep flip");

  // Fill level never passes the table depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(TABLE_DEPTH))
    else $error("fill level beyond table depth");

  // A frame update with room in the result register completes at once
  a_upd_emits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD && out_free |=> out_valid_r && out_last_r && state_r == S_IDLE)
    else $error("frame update did not deliver its result");
`endif

endmodule
